[sv/ksd_pkg.sv]
// ksd_pkg: shared constants, register codes and step result type for the
// key sequence detector. No dependencies.
package ksd_pkg;

	localparam int NUM_SEQ_DEF = 4;
	localparam int MAX_LEN_DEF = 8;

	localparam int KEY_W     = 8;
	localparam int PAT_W     = 64;
	localparam int LEN_W     = 4;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 2;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W     = 2;
	localparam int BYTE_W    = KEY_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ZERO     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTHS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT     = 3'd5;

	localparam logic [BYTE_W-1:0] BYTE_WILDCARD = 9'h000;
	localparam logic [BYTE_W-1:0] BYTE_SKIP     = 9'h001;
	localparam logic [BYTE_W-1:0] BYTE_NONE     = 9'h100;

	localparam logic [CNT_W-1:0] MAX_CAPTURES = 2'd2;

	typedef struct packed {
		logic             done;
		logic             eat_set;
		logic             eat_val;
		logic             cap_wr;
		logic             cap_slot;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
	} ksd_step_t;

endpackage

[sv/ksd_cfg.sv]
// ksd_cfg: configuration registers (patterns, lengths, active count).
// Depends on ksd_pkg.
module ksd_cfg
	import ksd_pkg::*;
#(
	parameter int NUM_SEQ = NUM_SEQ_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [PAT_W-1:0]                       cfg_data,
	output logic [NUM_SEQ-1:0][MAX_LEN*KEY_W-1:0]  patterns,
	output logic [NUM_SEQ-1:0][LEN_W-1:0]          lengths,
	output logic [ACT_W-1:0]                       active
);

	localparam logic [ACT_W-1:0] ACT_MAX = ACT_W'(NUM_SEQ);

	logic [NUM_SEQ-1:0][MAX_LEN*KEY_W-1:0] pat_q;
	logic [NUM_SEQ-1:0][LEN_W-1:0]         len_q;
	logic [ACT_W-1:0]                      act_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
			act_q <= '0;
		end else if (cfg_valid) begin
			for (int s = 0; s < NUM_SEQ; s++) begin
				if (cfg_index == REG_PATTERN_ZERO + CFG_IDX_W'(s))
					pat_q[s] <= cfg_data[MAX_LEN*KEY_W-1:0];
				if (cfg_index == REG_SEQUENCE_LENGTHS)
					len_q[s] <= cfg_data[LEN_W*s +: LEN_W];
			end
			if (cfg_index == REG_ACTIVE_COUNT)
				act_q <= cfg_data[ACT_W-1:0];
		end
	end

	assign patterns = pat_q;
	assign lengths  = len_q;
	assign active   = (act_q > ACT_MAX) ? ACT_MAX : act_q;

endmodule

[sv/ksd_step.sv]
// ksd_step: next match position, capture and completion of one pattern.
// Depends on ksd_pkg.
module ksd_step
	import ksd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic [MAX_LEN*KEY_W-1:0] pattern,
	input  logic [LEN_W-1:0]         length,
	input  logic [POS_W-1:0]         pos,
	input  logic [CNT_W-1:0]         cnt,
	input  logic [KEY_W-1:0]         key,
	output ksd_step_t                res
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

	function automatic logic [BYTE_W-1:0] byte_at(
		input logic [MAX_LEN*KEY_W-1:0] pat,
		input logic [POS_W:0]           p
	);
		logic [BYTE_W-1:0] b;
		b = BYTE_NONE;
		for (int j = 0; j < MAX_LEN; j++) begin
			if (p == (POS_W+1)'(j))
				b = {1'b0, pat[KEY_W*j +: KEY_W]};
		end
		return b;
	endfunction

	logic [BYTE_W-1:0] cur;
	logic [POS_W:0]    p1;
	logic [POS_W:0]    p2;
	logic [CNT_W-1:0]  cnt_n;
	logic [LEN_W-1:0]  len_eff;

	always_comb begin
		res      = '0;
		cnt_n    = cnt;
		len_eff  = (length > LEN_MAX) ? LEN_MAX : length;
		cur      = byte_at(pattern, {1'b0, pos});
		if (cur == BYTE_WILDCARD) begin
			if (cnt < MAX_CAPTURES) begin
				res.cap_wr   = 1'b1;
				res.cap_slot = cnt[0];
				cnt_n        = cnt + 1'b1;
			end
			p1          = {1'b0, pos} + 1'b1;
			res.eat_set = 1'b1;
			res.eat_val = 1'b1;
		end else if (cur == {1'b0, key}) begin
			p1          = {1'b0, pos} + 1'b1;
			res.eat_set = 1'b1;
			res.eat_val = 1'b0;
		end else begin
			p1    = '0;
			cnt_n = '0;
		end
		p2 = (byte_at(pattern, p1) == BYTE_SKIP) ? p1 + 1'b1 : p1;
		if (p2 >= {1'b0, len_eff}) begin
			res.done = 1'b1;
			res.pos  = '0;
			res.cnt  = '0;
		end else begin
			res.pos = p2[POS_W-1:0];
			res.cnt = cnt_n;
		end
	end

endmodule

[sv/key_sequence_detector_top.sv]
// key_sequence_detector_top: input register, per-pattern step units with
// priority merge, and result register. Depends on ksd_pkg, ksd_cfg, ksd_step.
// An accepted word is held in the input register, then its result registered.
// Throughput: one word per cycle unless out_stall holds; state feeds back.
// Reset: arst_n clears configuration, match state, captures and valids.
module key_sequence_detector_top
	import ksd_pkg::*;
#(
	parameter int NUM_SEQ = NUM_SEQ_DEF,
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 key_down,
	input  logic [KEY_W-1:0]     key_code,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 consumed,
	output logic                 matched,
	output logic [IDX_W-1:0]     match_index,
	output logic [KEY_W-1:0]     arg_first,
	output logic [KEY_W-1:0]     arg_second
);

	logic [NUM_SEQ-1:0][MAX_LEN*KEY_W-1:0] patterns;
	logic [NUM_SEQ-1:0][LEN_W-1:0]         lengths;
	logic [ACT_W-1:0]                      active;

	logic             v_s1;
	logic             down_s1;
	logic [KEY_W-1:0] key_s1;

	logic [POS_W-1:0] pos_q [NUM_SEQ];
	logic [CNT_W-1:0] cnt_q [NUM_SEQ];
	logic [KEY_W-1:0] cap_q [NUM_SEQ][2];

	logic [POS_W-1:0] pos_n [NUM_SEQ];
	logic [CNT_W-1:0] cnt_n [NUM_SEQ];
	logic [KEY_W-1:0] cap_n [NUM_SEQ][2];

	ksd_step_t res [NUM_SEQ];

	logic             out_valid_q;
	logic             consumed_q;
	logic             matched_q;
	logic [IDX_W-1:0] index_q;
	logic [KEY_W-1:0] arg1_q;
	logic [KEY_W-1:0] arg2_q;

	logic             adv;
	logic             fire;
	logic             eat;
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic [KEY_W-1:0] a1;
	logic [KEY_W-1:0] a2;

	ksd_cfg #(
		.NUM_SEQ (NUM_SEQ),
		.MAX_LEN (MAX_LEN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.patterns  (patterns),
		.lengths   (lengths),
		.active    (active)
	);

	for (genvar s = 0; s < NUM_SEQ; s++) begin : g_step
		ksd_step #(
			.MAX_LEN (MAX_LEN)
		) u_step (
			.pattern (patterns[s]),
			.length  (lengths[s]),
			.pos     (pos_q[s]),
			.cnt     (cnt_q[s]),
			.key     (key_s1),
			.res     (res[s])
		);
	end

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = v_s1 && adv;
	assign in_stall = v_s1 && !adv;

	// patterns in index order; the first to complete shadows the rest
	always_comb begin
		eat     = 1'b0;
		hit     = 1'b0;
		hit_idx = '0;
		a1      = '0;
		a2      = '0;
		for (int s = 0; s < NUM_SEQ; s++) begin
			pos_n[s]    = pos_q[s];
			cnt_n[s]    = cnt_q[s];
			cap_n[s][0] = cap_q[s][0];
			cap_n[s][1] = cap_q[s][1];
			if (down_s1 && (ACT_W'(s) < active) && !hit) begin
				pos_n[s] = res[s].pos;
				cnt_n[s] = res[s].cnt;
				if (res[s].cap_wr)
					cap_n[s][res[s].cap_slot] = key_s1;
				if (res[s].eat_set)
					eat = res[s].eat_val;
				if (res[s].done) begin
					hit     = 1'b1;
					hit_idx = IDX_W'(s);
					a1      = cap_n[s][0];
					a2      = cap_n[s][1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			down_s1 <= key_down;
			key_s1  <= key_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SEQ; s++) begin
				pos_q[s]    <= '0;
				cnt_q[s]    <= '0;
				cap_q[s][0] <= '0;
				cap_q[s][1] <= '0;
			end
		end else if (fire) begin
			for (int s = 0; s < NUM_SEQ; s++) begin
				pos_q[s]    <= pos_n[s];
				cnt_q[s]    <= cnt_n[s];
				cap_q[s][0] <= cap_n[s][0];
				cap_q[s][1] <= cap_n[s][1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			consumed_q <= hit || eat;
			matched_q  <= hit;
			index_q    <= hit_idx;
			arg1_q     <= a1;
			arg2_q     <= a2;
		end
	end

	assign out_valid   = out_valid_q;
	assign consumed    = consumed_q;
	assign matched     = matched_q;
	assign match_index = index_q;
	assign arg_first   = arg1_q;
	assign arg_second  = arg2_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for key_sequence_detector_top, with a word-level
// predictor, a queued key driver, a result monitor and config rounds. Depends on ksd_pkg.
module tb_top;
	import ksd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ROUNDS      = 14;
	localparam int ROUND_WORDS = 125;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = REG_ACTIVE_COUNT + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = REG_ACTIVE_COUNT + 3'd2;

	typedef struct packed {
		logic             down;
		logic [KEY_W-1:0] code;
	} key_event_t;

	typedef struct packed {
		logic             consumed;
		logic             matched;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] arg_a;
		logic [KEY_W-1:0] arg_b;
	} key_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 key_down;
	logic [KEY_W-1:0]     key_code;
	logic                 out_valid;
	logic                 out_stall;
	logic                 consumed;
	logic                 matched;
	logic [IDX_W-1:0]     match_index;
	logic [KEY_W-1:0]     arg_first;
	logic [KEY_W-1:0]     arg_second;

	// predictor copy of configuration and match state
	logic [PAT_W-1:0] pat_shadow [NUM_SEQ_DEF];
	logic [15:0]      len_shadow;
	logic [ACT_W-1:0] act_shadow;
	logic [POS_W-1:0] seq_pos [NUM_SEQ_DEF];
	logic [CNT_W-1:0] cap_cnt [NUM_SEQ_DEF];
	logic [KEY_W-1:0] cap_key [2*NUM_SEQ_DEF];

	key_event_t  key_queue [$];
	key_result_t expected_results [$];
	key_event_t  drive_word;
	key_result_t result_want;
	logic [KEY_W-1:0] key_set [4];

	logic in_fire;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   error_count;
	int   cycle_count;

	key_sequence_detector_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_down    (key_down),
		.key_code    (key_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.consumed    (consumed),
		.matched     (matched),
		.match_index (match_index),
		.arg_first   (arg_first),
		.arg_second  (arg_second)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [BYTE_W-1:0] pattern_byte_at(input int s, input int pos);
		if (pos >= MAX_LEN_DEF)
			return BYTE_NONE;
		return {1'b0, pat_shadow[s][8*pos +: 8]};
	endfunction

	function automatic key_result_t detect_key(input logic down, input logic [KEY_W-1:0] code);
		key_result_t       r;
		logic              eat;
		int                lim;
		int                len;
		int                pos;
		logic [BYTE_W-1:0] cur;
		r = '0;
		eat = 1'b0;
		if (!down)
			return r;
		lim = (act_shadow > NUM_SEQ_DEF) ? NUM_SEQ_DEF : int'(act_shadow);
		for (int s = 0; s < lim; s++) begin
			pos = seq_pos[s];
			cur = pattern_byte_at(s, pos);
			if (cur == BYTE_WILDCARD) begin
				if (cap_cnt[s] < MAX_CAPTURES) begin
					cap_key[2*s + cap_cnt[s]] = code;
					cap_cnt[s] = cap_cnt[s] + 1'b1;
				end
				pos++;
				eat = 1'b1;
			end else if (cur == {1'b0, code}) begin
				pos++;
				eat = 1'b0;
			end else begin
				pos = 0;
				cap_cnt[s] = '0;
			end
			if (pattern_byte_at(s, pos) == BYTE_SKIP)
				pos++;
			len = len_shadow[4*s +: 4];
			if (len > MAX_LEN_DEF)
				len = MAX_LEN_DEF;
			if (pos >= len) begin
				seq_pos[s] = '0;
				cap_cnt[s] = '0;
				r.consumed = 1'b1;
				r.matched = 1'b1;
				r.idx = s[IDX_W-1:0];
				r.arg_a = cap_key[2*s];
				r.arg_b = cap_key[2*s + 1];
				return r;
			end
			seq_pos[s] = pos[POS_W-1:0];
		end
		r.consumed = eat;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			if (error_count <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_word = key_queue.pop_front();
					in_valid <= 1'b1;
					key_down <= drive_word.down;
					key_code <= drive_word.code;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				expected_results.push_back(detect_key(key_down, key_code));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result word: consumed %0b matched %0b index %0d",
							consumed, matched, match_index);
				end else begin
					result_want = expected_results.pop_front();
					check_field("consumed", result_want.consumed, consumed);
					check_field("matched", result_want.matched, matched);
					check_field("match_index", result_want.idx, match_index);
					check_field("arg_first", result_want.arg_a, arg_first);
					check_field("arg_second", result_want.arg_b, arg_second);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx >= REG_PATTERN_ZERO && idx < REG_PATTERN_ZERO + NUM_SEQ_DEF)
			pat_shadow[idx - REG_PATTERN_ZERO] = data;
		else if (idx == REG_SEQUENCE_LENGTHS)
			len_shadow = data[15:0];
		else if (idx == REG_ACTIVE_COUNT)
			act_shadow = data[ACT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void push_key(input logic down, input logic [KEY_W-1:0] code);
		key_queue.push_back({down, code});
	endfunction

	// walk one pattern with random wildcard content; returns words queued
	function automatic int push_sequence(input int s);
		int               len;
		int               cnt;
		logic [KEY_W-1:0] b;
		cnt = 0;
		len = len_shadow[4*s +: 4];
		if (len > MAX_LEN_DEF)
			len = MAX_LEN_DEF;
		if (len == 0) begin
			push_key(1'b1, KEY_W'($urandom_range(255)));
			return 1;
		end
		for (int j = 0; j < len; j++) begin
			b = pat_shadow[s][8*j +: 8];
			if ($urandom_range(15) == 0) begin
				push_key(1'b0, KEY_W'($urandom_range(255)));
				cnt++;
			end
			if (!(b == BYTE_SKIP[KEY_W-1:0] && j != 0)) begin
				if (b == BYTE_WILDCARD[KEY_W-1:0])
					push_key(1'b1, KEY_W'($urandom_range(255)));
				else
					push_key(1'b1, b);
				cnt++;
			end
		end
		return cnt;
	endfunction

	task automatic fill_keys(input int quota);
		int n;
		int pick;
		int lim;
		n = 0;
		lim = (act_shadow > NUM_SEQ_DEF) ? NUM_SEQ_DEF : int'(act_shadow);
		@(posedge clk);
		while (n < quota) begin
			pick = $urandom_range(99);
			if (pick < 75 && lim > 0) begin
				n += push_sequence($urandom_range(lim - 1));
			end else if (pick < 85) begin
				push_key(1'b0, KEY_W'($urandom_range(255)));
				n++;
			end else if (pick < 93) begin
				push_key(1'b1, key_set[$urandom_range(3)]);
				n++;
			end else begin
				push_key(1'b1, KEY_W'($urandom_range(255)));
				n++;
			end
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (key_queue.size() != 0 || in_valid || out_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure_round(input int round);
		logic [PAT_W-1:0] pat;
		logic [15:0]      lens;
		logic [ACT_W-1:0] act;
		int               r;
		for (int k = 0; k < 4; k++)
			key_set[k] = KEY_W'($urandom_range(2, 255));
		for (int s = 0; s < NUM_SEQ_DEF; s++) begin
			if (round == 0)
				pat = '1;
			else if (round == 1)
				pat = '0;
			else if ($urandom_range(9) == 0)
				pat = {$urandom, $urandom};
			else begin
				for (int j = 0; j < 8; j++) begin
					r = $urandom_range(99);
					if (r < 25)
						pat[8*j +: 8] = BYTE_WILDCARD[KEY_W-1:0];
					else if (r < 35)
						pat[8*j +: 8] = BYTE_SKIP[KEY_W-1:0];
					else
						pat[8*j +: 8] = key_set[$urandom_range(3)];
				end
			end
			write_reg(REG_PATTERN_ZERO + CFG_IDX_W'(s), pat);
		end
		if (round == 0)
			lens = 16'hFFFF;
		else if (round == 1)
			lens = 16'h0000;
		else begin
			for (int s = 0; s < NUM_SEQ_DEF; s++) begin
				r = $urandom_range(9);
				if (r == 0)
					lens[4*s +: 4] = 4'd0;
				else if (r == 1)
					lens[4*s +: 4] = LEN_W'($urandom_range(9, 15));
				else
					lens[4*s +: 4] = LEN_W'($urandom_range(1, 8));
			end
		end
		write_reg(REG_SEQUENCE_LENGTHS, {48'd0, lens});
		if (round == 0)
			act = 3'd7;
		else if (round == 1)
			act = 3'd4;
		else begin
			r = $urandom_range(9);
			if (r == 0)
				act = 3'd0;
			else if (r == 1)
				act = ACT_W'($urandom_range(5, 7));
			else
				act = ACT_W'($urandom_range(1, 4));
		end
		write_reg(REG_ACTIVE_COUNT, {61'd0, act});
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		key_down = 1'b0;
		key_code = '0;
		out_stall = 1'b0;
		in_fire = 1'b0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 30;
		recv_idle_pct = 62;
		len_shadow = '0;
		act_shadow = '0;
		for (int s = 0; s < NUM_SEQ_DEF; s++) begin
			pat_shadow[s] = '0;
			seq_pos[s] = '0;
			cap_cnt[s] = '0;
			cap_key[2*s] = '0;
			cap_key[2*s + 1] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: literal, wildcard, skip, overflow captures, clamped length and count
		write_reg(REG_PATTERN_ZERO, 64'h0000_0000_4201_0041);
		write_reg(REG_PATTERN_ZERO + CFG_IDX_W'(1), 64'h0000_0000_4300_0000);
		write_reg(REG_PATTERN_ZERO + CFG_IDX_W'(2), 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PATTERN_ZERO + CFG_IDX_W'(3), 64'h0000_0000_0000_0000);
		write_reg(REG_SEQUENCE_LENGTHS, 64'h0000_0000_0000_0F44);
		write_reg(REG_ACTIVE_COUNT, 64'd7);
		@(posedge clk);
		push_key(1'b0, 8'hFF);
		push_key(1'b0, 8'h00);
		push_key(1'b1, 8'h41);
		push_key(1'b1, 8'h7E);
		push_key(1'b1, 8'h42);
		push_key(1'b1, 8'h11);
		push_key(1'b1, 8'h22);
		push_key(1'b1, 8'h33);
		push_key(1'b1, 8'h43);
		push_key(1'b1, 8'h00);
		push_key(1'b1, 8'hFF);
		push_key(1'b1, 8'h01);
		drain();
		write_reg(REG_SPARE_A, {$urandom, $urandom});
		write_reg(REG_SPARE_B, {$urandom, $urandom});
		write_reg(REG_ACTIVE_COUNT, 64'd3);
		@(posedge clk);
		push_key(1'b1, 8'h41);
		push_key(1'b1, 8'h5A);
		push_key(1'b1, 8'h42);
		push_key(1'b1, 8'hFF);
		push_key(1'b1, 8'hFF);
		push_key(1'b1, 8'hFF);
		push_key(1'b1, 8'h80);
		push_key(1'b1, 8'h01);
		drain();

		for (int round = 0; round < ROUNDS; round++) begin
			configure_round(round);
			@(posedge clk);
			if (round < 5) begin
				send_idle_pct = 30;
				recv_idle_pct = 62;
			end else if (round < 10) begin
				send_idle_pct = 62;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			fill_keys(ROUND_WORDS / 2);
			// hold off until every outstanding result is back
			drain();
			fill_keys(ROUND_WORDS - ROUND_WORDS / 2);
			drain();
		end

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
